@@ src/erc_pkg.sv @@
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants of the ring counter store.
// ----------------------------------------------------------------------------
`default_nettype none

package erc_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int SLOT_BYTES  = 4;
  localparam int SLOT_COUNT  = STORE_BYTES / SLOT_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int BYTE_W      = 8;
  localparam int VAL_W       = SLOT_BYTES * BYTE_W;

  typedef logic [1:0]        op_t;
  typedef logic [ADDR_W-1:0] loc_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam op_t OP_WRITE   = 2'd0;
  localparam op_t OP_READ    = 2'd1;
  localparam op_t OP_RECOVER = 2'd2;

endpackage

`default_nettype wire

@@ src/erc_if.sv @@
// ----------------------------------------------------------------------------
// erc_in_if / erc_out_if
// Valid/ready channels for requests and results of the ring counter store.
// ----------------------------------------------------------------------------
`default_nettype none

interface erc_in_if;
  logic           valid;
  logic           ready;
  erc_pkg::op_t   operation;
  erc_pkg::val_t  counter_value;
  erc_pkg::loc_t  byte_location;

  modport source (output valid, output operation, output counter_value,
                  output byte_location, input ready);
  modport sink   (input valid, input operation, input counter_value,
                  input byte_location, output ready);
endinterface

interface erc_out_if;
  logic           valid;
  logic           ready;
  erc_pkg::val_t  result_value;
  erc_pkg::loc_t  result_location;

  modport source (output valid, output result_value, output result_location,
                  input ready);
  modport sink   (input valid, input result_value, input result_location,
                  output ready);
endinterface

`default_nettype wire

@@ src/eeprom_ring_counter_store_core.sv @@
// ----------------------------------------------------------------------------
// eeprom_ring_counter_store_core
// Byte-wide counter store with write, read and largest-slot recovery.
// ----------------------------------------------------------------------------
// The counters live in one byte-wide synchronous memory with one write port
// and one registered read port, so every transaction goes through the memory
// one byte at a time. After reset the block clears every byte of the memory
// before it takes its first request. A recover walks every byte of the store.
// One request is worked on at a time; a finished result waits in the output
// register while the next request is accepted.
`default_nettype none

module eeprom_ring_counter_store_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  erc_in_if.sink     in_ch,
  erc_out_if.source  out_ch
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_WRITE   = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_RECOVER = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  localparam erc_pkg::cnt_t SLOT_CNT  = erc_pkg::cnt_t'(erc_pkg::SLOT_BYTES);
  localparam erc_pkg::cnt_t STORE_CNT = erc_pkg::cnt_t'(erc_pkg::STORE_BYTES);
  localparam erc_pkg::loc_t LAST_LOC  = erc_pkg::loc_t'(erc_pkg::STORE_BYTES - 1);

  erc_pkg::byte_t mem [erc_pkg::STORE_BYTES];
  erc_pkg::byte_t rdata_r;

  logic [2:0]     state_r, state_nxt;
  erc_pkg::loc_t  iss_addr_r, iss_addr_nxt;
  erc_pkg::cnt_t  iss_cnt_r, iss_cnt_nxt;
  erc_pkg::cnt_t  rcv_cnt_r, rcv_cnt_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  erc_pkg::loc_t  rd_addr_r, rd_addr_nxt;
  erc_pkg::loc_t  loc_r, loc_nxt;
  erc_pkg::val_t  val_r, val_nxt;
  erc_pkg::val_t  acc_r, acc_nxt;
  erc_pkg::val_t  best_r, best_nxt;
  erc_pkg::loc_t  best_loc_r, best_loc_nxt;
  erc_pkg::val_t  res_val_r, res_val_nxt;
  erc_pkg::loc_t  res_loc_r, res_loc_nxt;
  logic           out_valid_r, out_valid_nxt;
  erc_pkg::val_t  out_val_r, out_val_nxt;
  erc_pkg::loc_t  out_loc_r, out_loc_nxt;

  logic           mem_we;
  erc_pkg::loc_t  mem_waddr;
  erc_pkg::byte_t mem_wdata;
  erc_pkg::cnt_t  total;
  erc_pkg::val_t  word;
  erc_pkg::loc_t  slot_loc;
  logic           accept;

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign accept                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_value    = out_val_r;
  assign out_ch.result_location = out_loc_r;

  assign total    = (state_r == ST_READ) ? SLOT_CNT : STORE_CNT;
  assign word     = {acc_r[erc_pkg::VAL_W-erc_pkg::BYTE_W-1:0], rdata_r};
  assign slot_loc = {rd_addr_r[erc_pkg::ADDR_W-1:2], 2'b00};

  always_comb begin
    state_nxt     = state_r;
    iss_addr_nxt  = iss_addr_r;
    iss_cnt_nxt   = iss_cnt_r;
    rcv_cnt_nxt   = rcv_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    loc_nxt       = loc_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    best_loc_nxt  = best_loc_r;
    res_val_nxt   = res_val_r;
    res_loc_nxt   = res_loc_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_loc_nxt   = out_loc_r;
    mem_we        = 1'b0;
    mem_waddr     = iss_addr_r;
    mem_wdata     = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r) inside
      ST_CLEAR: begin
        mem_we       = 1'b1;
        iss_addr_nxt = iss_addr_r + 1'b1;
        if (iss_addr_r == LAST_LOC) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          loc_nxt      = in_ch.byte_location;
          val_nxt      = in_ch.counter_value;
          iss_addr_nxt = in_ch.byte_location;
          iss_cnt_nxt  = '0;
          rcv_cnt_nxt  = '0;
          best_nxt     = '0;
          best_loc_nxt = '0;
          unique case (in_ch.operation)
            erc_pkg::OP_WRITE:   state_nxt = ST_WRITE;
            erc_pkg::OP_READ:    state_nxt = ST_READ;
            erc_pkg::OP_RECOVER: begin
              iss_addr_nxt = '0;
              state_nxt    = ST_RECOVER;
            end
            default: begin
              res_val_nxt = '0;
              res_loc_nxt = '0;
              state_nxt   = ST_DONE;
            end
          endcase
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        case (iss_cnt_r[1:0])
          2'd0:    mem_wdata = val_r[31:24];
          2'd1:    mem_wdata = val_r[23:16];
          2'd2:    mem_wdata = val_r[15:8];
          default: mem_wdata = val_r[7:0];
        endcase
        iss_addr_nxt = iss_addr_r + 1'b1;
        iss_cnt_nxt  = iss_cnt_r + 1'b1;
        if (iss_cnt_r[1:0] == 2'd3) begin
          res_val_nxt = '0;
          res_loc_nxt = loc_r + erc_pkg::loc_t'(erc_pkg::SLOT_BYTES);
          state_nxt   = ST_DONE;
        end
      end
      ST_READ, ST_RECOVER: begin
        if (iss_cnt_r != total) begin
          rd_pend_nxt  = 1'b1;
          rd_addr_nxt  = iss_addr_r;
          iss_addr_nxt = iss_addr_r + 1'b1;
          iss_cnt_nxt  = iss_cnt_r + 1'b1;
        end
        if (rd_pend_r) begin
          acc_nxt     = word;
          rcv_cnt_nxt = rcv_cnt_r + 1'b1;
          if ((state_r == ST_RECOVER) && (rcv_cnt_r[1:0] == 2'd3) && (word > best_r)) begin
            best_nxt     = word;
            best_loc_nxt = slot_loc;
          end
          if (rcv_cnt_r == total - 1'b1) begin
            if (state_r == ST_READ) begin
              res_val_nxt = word;
              res_loc_nxt = loc_r;
            end else begin
              res_val_nxt = best_nxt;
              res_loc_nxt = best_loc_nxt;
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_loc_nxt   = res_loc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[iss_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      iss_addr_r  <= '0;
      iss_cnt_r   <= '0;
      rcv_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_addr_r  <= iss_addr_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      rcv_cnt_r   <= rcv_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    loc_r      <= loc_nxt;
    val_r      <= val_nxt;
    acc_r      <= acc_nxt;
    best_r     <= best_nxt;
    best_loc_r <= best_loc_nxt;
    res_val_r  <= res_val_nxt;
    res_loc_r  <= res_loc_nxt;
    out_val_r  <= out_val_nxt;
    out_loc_r  <= out_loc_nxt;
  end

  // A write never spans more than one slot of bytes.
  a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (iss_cnt_r < SLOT_CNT))
    else $error("write ran past one slot");

  // Returned read data only arrives while a gather is in progress.
  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> ((state_r == ST_READ) || (state_r == ST_RECOVER)))
    else $error("read data outside a gather");

  // A finished result waits while the output register is still held.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_valid_r && !out_ch.ready) |=> (state_r == ST_DONE))
    else $error("result overwrote a pending output");

  // Recovery only ever records slot-aligned positions.
  a_best_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RECOVER) |-> (best_loc_r[1:0] == 2'b00))
    else $error("unaligned recover position");

endmodule

`default_nettype wire
